// ----- hdl/vte_pkg.sv -----
// ----------------------------------------------------------------------------
// vte_pkg
// Shared types, constants and helper functions of the varint TLV encoder.
// ----------------------------------------------------------------------------
package vte_pkg;

  typedef enum logic [1:0] {
    REQ_INT = 2'd0,
    REQ_F32 = 2'd1,
    REQ_F64 = 2'd2,
    REQ_HDR = 2'd3
  } req_type_t;

  localparam logic [7:0]  MAGIC0   = 8'hAB;
  localparam logic [7:0]  MAGIC1   = 8'hCF;
  localparam logic [7:0]  LEN_F32  = 8'd4;
  localparam logic [7:0]  LEN_F64  = 8'd8;
  localparam logic [15:0] CRC_POLY = 16'h8380;  // 0x1070 << 3
  localparam int          VLEN_W   = 4;          // holds 1..10
  localparam int          QDEPTH   = 2;

  // One classified request waiting for serialization.
  typedef struct packed {
    req_type_t         req;
    logic [7:0]        tag;
    logic [63:0]       data;   // value, or frame length zero-extended
    logic [VLEN_W-1:0] nlen;   // varint byte count of data
  } vte_entry_t;

  // Fold one id byte into the 16-bit CRC accumulator (8 steps).
  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in,
                                           input logic [7:0]  b);
    logic [15:0] acc;
    acc = acc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = acc ^ CRC_POLY;
      end
      acc = {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  // Number of 7-bit groups needed to hold v (at least one).
  function automatic logic [VLEN_W-1:0] varint_len(input logic [63:0] v);
    logic [VLEN_W-1:0] len;
    len = VLEN_W'(1);
    for (int k = 1; k < 10; k++) begin
      if ((v >> (7 * k)) != 64'd0) begin
        len = VLEN_W'(k + 1);
      end
    end
    return len;
  endfunction

endpackage

// ----- hdl/vte_front.sv -----
// ----------------------------------------------------------------------------
// vte_front
// Accepts a request, hashes the field id one byte per cycle, queues the result.
// ----------------------------------------------------------------------------
module vte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic [31:0]         in_field_id,
  input  logic [63:0]         in_value,
  input  logic [31:0]         in_frame_length,
  input  logic                q_full,
  output logic                q_push,
  output vte_pkg::vte_entry_t q_entry
);
  import vte_pkg::*;

  logic              occ_r;
  logic [1:0]        cnt_r;
  logic [15:0]       acc_r;
  logic [31:0]       id_r;
  req_type_t         req_r;
  logic [63:0]       data_r;
  logic [VLEN_W-1:0] nlen_r;
  logic [7:0]        id_byte;
  logic [15:0]       acc_nxt;
  logic [63:0]       data_in;

  assign busy = occ_r;

  assign data_in = (req_type_t'(in_req_type) == REQ_HDR) ? {32'd0, in_frame_length}
                                                         : in_value;

  always_comb begin
    unique case (cnt_r)
      2'd0:    id_byte = id_r[31:24];
      2'd1:    id_byte = id_r[23:16];
      2'd2:    id_byte = id_r[15:8];
      default: id_byte = id_r[7:0];
    endcase
  end

  assign acc_nxt = crc_byte(acc_r, id_byte);

  // last id byte is folded on the fly while the entry is pushed
  assign q_push        = occ_r && (cnt_r == 2'd3) && !q_full;
  assign q_entry.req   = req_r;
  assign q_entry.tag   = acc_nxt[15:8];
  assign q_entry.data  = data_r;
  assign q_entry.nlen  = nlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      cnt_r <= 2'd0;
    end else if (!occ_r) begin
      if (start) begin
        occ_r  <= 1'b1;
        cnt_r  <= 2'd0;
        acc_r  <= 16'd0;
        id_r   <= in_field_id;
        req_r  <= req_type_t'(in_req_type);
        data_r <= data_in;
        nlen_r <= varint_len(data_in);
      end
    end else if (cnt_r != 2'd3) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_r + 2'd1;
    end else if (q_push) begin
      occ_r <= 1'b0;
    end
  end

endmodule

// ----- hdl/vte_fifo.sv -----
// ----------------------------------------------------------------------------
// vte_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module vte_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  vte_pkg::vte_entry_t wr_entry,
  output logic                full,
  input  logic                pop,
  output vte_pkg::vte_entry_t rd_entry,
  output logic                empty
);
  import vte_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  vte_entry_t       mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/vte_back.sv -----
// ----------------------------------------------------------------------------
// vte_back
// Byte sequencer: turns one queued request into its serialized byte stream.
// ----------------------------------------------------------------------------
module vte_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  vte_pkg::vte_entry_t q_entry,
  output logic                q_pop,
  output logic                out_strobe,
  output logic [7:0]          out_byte,
  output logic                out_last_byte
);
  import vte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MAG0, S_MAG1, S_TAG0, S_TAG1, S_LEN, S_VAR, S_RAW
  } state_t;

  state_t            state_r;
  req_type_t         req_r;
  logic [7:0]        tag_r;
  logic [63:0]       sh_r;
  logic [VLEN_W-1:0] nlen_r;
  logic [VLEN_W-1:0] cnt_r;
  logic              strobe_r;
  logic [7:0]        byte_r;
  logic              last_r;

  logic [7:0]        byte_c;
  logic              last_c;
  logic              emit_c;

  always_comb begin
    byte_c = 8'd0;
    last_c = 1'b0;
    emit_c = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: ;
      S_MAG0: byte_c = MAGIC0;
      S_MAG1: byte_c = MAGIC1;
      S_TAG0: byte_c = tag_r[7] ? {1'b1, tag_r[6:0]} : tag_r;
      S_TAG1: byte_c = {7'd0, tag_r[7]};
      S_LEN: begin
        unique case (req_r)
          REQ_INT: byte_c = {{(8 - VLEN_W){1'b0}}, nlen_r};
          REQ_F32: byte_c = LEN_F32;
          default: byte_c = LEN_F64;
        endcase
      end
      S_VAR: begin
        last_c = (cnt_r == VLEN_W'(1));
        byte_c = {!last_c, sh_r[6:0]};
      end
      S_RAW: begin
        last_c = (cnt_r == VLEN_W'(1));
        byte_c = sh_r[63:56];
      end
      default: ;
    endcase
  end

  // next entry loads in the cycle the current run emits its last byte
  assign q_pop = !q_empty && ((state_r == S_IDLE) || last_c);

  assign out_strobe    = strobe_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      strobe_r <= emit_c;
      byte_r   <= byte_c;
      last_r   <= last_c;
      if (q_pop) begin
        req_r   <= q_entry.req;
        tag_r   <= q_entry.tag;
        sh_r    <= q_entry.data;
        nlen_r  <= q_entry.nlen;
        cnt_r   <= q_entry.nlen;
        state_r <= (q_entry.req == REQ_HDR) ? S_MAG0 : S_TAG0;
      end else begin
        unique case (state_r)
          S_IDLE: ;
          S_MAG0: state_r <= S_MAG1;
          S_MAG1: state_r <= S_VAR;
          S_TAG0: state_r <= tag_r[7] ? S_TAG1 : S_LEN;
          S_TAG1: state_r <= S_LEN;
          S_LEN: begin
            unique case (req_r)
              REQ_INT: begin
                cnt_r   <= nlen_r;
                state_r <= S_VAR;
              end
              REQ_F32: begin
                sh_r    <= {sh_r[31:0], 32'd0};
                cnt_r   <= VLEN_W'(4);
                state_r <= S_RAW;
              end
              default: begin
                cnt_r   <= VLEN_W'(8);
                state_r <= S_RAW;
              end
            endcase
          end
          S_VAR: begin
            sh_r  <= {7'd0, sh_r[63:7]};
            cnt_r <= cnt_r - VLEN_W'(1);
            if (last_c) begin
              state_r <= S_IDLE;
            end
          end
          S_RAW: begin
            sh_r  <= {sh_r[55:0], 8'd0};
            cnt_r <= cnt_r - VLEN_W'(1);
            if (last_c) begin
              state_r <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- hdl/varint_tlv_field_encoder.sv -----
// ----------------------------------------------------------------------------
// varint_tlv_field_encoder
// Serializes fields to TLV bytes with LEB128 varints; headers to magic+length.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_* and raise start; the transaction is taken at
//   an edge where start is high and busy is low. busy is high while the
//   front stage still hashes the previous field id or waits for room in the
//   two-entry queue.
//   Result channel: one byte per cycle on out_byte, qualified by out_strobe;
//   out_last_byte flags the final byte of each request. The receiver cannot
//   stall, so the bytes of each request leave at one per cycle.
//   The first byte of a request passes CRC folding, the queue, the sequencer
//   and the output register.
//   Each request yields 3 to 13 bytes. The front stage takes the next request
//   only after it has hashed the field id and handed the entry to the queue;
//   long runs are paced by the byte sequencer at one byte a cycle, and the
//   next queued request follows its predecessor's last byte with no gap.
//   Reset (rst_n low, synchronous) empties the front stage, the queue and
//   the sequencer; no bytes are strobed until a new request arrives.
// ----------------------------------------------------------------------------
module varint_tlv_field_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_field_id,
  input  logic [63:0] in_value,
  input  logic [31:0] in_frame_length,
  // result channel
  output logic        out_strobe,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);
  import vte_pkg::*;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  vte_entry_t q_wr_entry;
  vte_entry_t q_rd_entry;

  // Front: capture, varint length of the payload, CRC tag of the field id.
  vte_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_field_id     (in_field_id),
    .in_value        (in_value),
    .in_frame_length (in_frame_length),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_wr_entry)
  );

  // Queue decouples hashing from byte emission.
  vte_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  // Back: emits tag, length and payload (or magic and length) bytes.
  vte_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_entry       (q_rd_entry),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
